// ===== sv/pah_pkg.sv =====
// ----------------------------------------------------------------------------
// Pitch-angle histogram package
// Shared types and constants for the pitch-angle histogram block.
// ----------------------------------------------------------------------------
package pah_pkg;

    localparam int FIELD_W  = 32;
    localparam int WEIGHT_W = 32;
    localparam int VALUE_W  = 48;
    localparam int COS_W    = 15;
    localparam int QUO_W    = 16;
    localparam int CFG_W    = 16;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] REG_COS_MIN     = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

    localparam logic [15:0] COS_MIN_RESET     = 16'hC000;
    localparam logic [15:0] BIN_WIDTH_RESET   = 16'd164;
    localparam logic [8:0]  BINS_IN_USE_RESET = 9'd200;

    typedef struct packed {
        logic             zero;
        logic             negative;
        logic [COS_W-1:0] mag;
    } cos_result_t;

endpackage

// ===== sv/pah_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pah_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pah_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pah_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pah_pkg::QUO_W-1:0] dividend,
    input  logic [pah_pkg::QUO_W-1:0] divisor,
    output logic                      done,
    output logic [pah_pkg::QUO_W-1:0] quotient
);

    localparam int QW = pah_pkg::QUO_W;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [$clog2(QW)-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]         rem_reg, rem_next;
    logic [QW-1:0]         quo_reg, quo_next;
    logic [QW-1:0]         dvs_reg, dvs_next;
    logic [QW:0]           trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? QW'(trial - {1'b0, dvs_reg}) : trial[QW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == $clog2(QW)'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/pah_cos.sv =====
// ----------------------------------------------------------------------------
// Pitch-angle cosine unit
// Sequenced products on one shared multiplier, then a bit-serial search for
// the largest Q2.14 cosine c with c^2 |B|^2 |v|^2 <= (B.v)^2 2^28.
// ----------------------------------------------------------------------------
module pah_cos (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [pah_pkg::FIELD_W-1:0] field_x,
    input  logic signed [pah_pkg::FIELD_W-1:0] field_y,
    input  logic signed [pah_pkg::FIELD_W-1:0] field_z,
    input  logic signed [pah_pkg::FIELD_W-1:0] vel_x,
    input  logic signed [pah_pkg::FIELD_W-1:0] vel_y,
    input  logic signed [pah_pkg::FIELD_W-1:0] vel_z,
    output logic                               done,
    output pah_pkg::cos_result_t               result
);

    localparam int FW = pah_pkg::FIELD_W;
    localparam int CW = pah_pkg::COS_W;
    localparam int WW = 160;

    localparam logic [4:0] STEP_DOT0 = 5'd0;
    localparam logic [4:0] STEP_DOT2 = 5'd2;
    localparam logic [4:0] STEP_BB0  = 5'd3;
    localparam logic [4:0] STEP_BB2  = 5'd5;
    localparam logic [4:0] STEP_VV0  = 5'd6;
    localparam logic [4:0] STEP_VV2  = 5'd8;
    localparam logic [4:0] STEP_P0   = 5'd9;
    localparam logic [4:0] STEP_P3   = 5'd12;
    localparam logic [4:0] STEP_Q0   = 5'd13;
    localparam logic [4:0] STEP_Q3   = 5'd16;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SUM, S_SUB} state_t;

    state_t                 state_reg, state_next;
    logic [4:0]             step_reg, step_next;
    logic                   done_reg, done_next;
    pah_pkg::cos_result_t   result_reg, result_next;
    logic signed [FW-1:0]   bx_reg, by_reg, bz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [FW-1:0]   bx_next, by_next, bz_next, vx_next, vy_next, vz_next;
    logic signed [65:0]     prod_reg, prod_next;
    logic signed [65:0]     dot_reg, dot_next;
    logic [63:0]            bb_reg, bb_next, vv_reg, vv_next, mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [127:0]           p_reg, p_next, q_reg, q_next;
    logic [WW-1:0]          r_reg, r_next, xs_reg, xs_next, ps_reg, ps_next;
    logic [WW-1:0]          term_reg, term_next;
    logic [CW-1:0]          c_reg, c_next;
    logic [3:0]             j_reg, j_next;
    logic signed [32:0]     mul_a, mul_b;
    logic [63:0]            pp;
    logic [63:0]            vv_sum;
    logic [127:0]           q_sum;
    logic [WW:0]            sub_w;
    logic [CW-1:0]          bit_w;

    assign pp     = prod_reg[63:0];
    assign vv_sum = vv_reg + pp;
    assign q_sum  = q_reg + {pp, 64'd0};
    assign sub_w  = {1'b0, r_reg} - {1'b0, term_reg};
    assign bit_w  = CW'(1) << j_reg;

    always_comb
    begin
        case (step_reg)
            5'd0:    begin mul_a = 33'(bx_reg); mul_b = 33'(vx_reg); end
            5'd1:    begin mul_a = 33'(by_reg); mul_b = 33'(vy_reg); end
            5'd2:    begin mul_a = 33'(bz_reg); mul_b = 33'(vz_reg); end
            5'd3:    begin mul_a = 33'(bx_reg); mul_b = 33'(bx_reg); end
            5'd4:    begin mul_a = 33'(by_reg); mul_b = 33'(by_reg); end
            5'd5:    begin mul_a = 33'(bz_reg); mul_b = 33'(bz_reg); end
            5'd6:    begin mul_a = 33'(vx_reg); mul_b = 33'(vx_reg); end
            5'd7:    begin mul_a = 33'(vy_reg); mul_b = 33'(vy_reg); end
            5'd8:    begin mul_a = 33'(vz_reg); mul_b = 33'(vz_reg); end
            5'd9:    begin mul_a = {1'b0, bb_reg[31:0]};  mul_b = {1'b0, vv_reg[31:0]};  end
            5'd10:   begin mul_a = {1'b0, bb_reg[31:0]};  mul_b = {1'b0, vv_reg[63:32]}; end
            5'd11:   begin mul_a = {1'b0, bb_reg[63:32]}; mul_b = {1'b0, vv_reg[31:0]};  end
            5'd12:   begin mul_a = {1'b0, bb_reg[63:32]}; mul_b = {1'b0, vv_reg[63:32]}; end
            5'd13:   begin mul_a = {1'b0, mag_reg[31:0]};  mul_b = {1'b0, mag_reg[31:0]};  end
            5'd14:   begin mul_a = {1'b0, mag_reg[31:0]};  mul_b = {1'b0, mag_reg[63:32]}; end
            5'd15:   begin mul_a = {1'b0, mag_reg[63:32]}; mul_b = {1'b0, mag_reg[31:0]};  end
            5'd16:   begin mul_a = {1'b0, mag_reg[63:32]}; mul_b = {1'b0, mag_reg[63:32]}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        bx_next = bx_reg; by_next = by_reg; bz_next = bz_reg;
        vx_next = vx_reg; vy_next = vy_reg; vz_next = vz_reg;
        prod_next = prod_reg;
        dot_next  = dot_reg;
        bb_next   = bb_reg;
        vv_next   = vv_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        xs_next   = xs_reg;
        ps_next   = ps_reg;
        term_next = term_reg;
        c_next    = c_reg;
        j_next    = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    bx_next = field_x; by_next = field_y; bz_next = field_z;
                    vx_next = vel_x;   vy_next = vel_y;   vz_next = vel_z;
                    step_next  = STEP_DOT0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                step_next  = step_reg + 1'b1;
                state_next = S_MUL;
                if (step_reg == STEP_DOT0)
                begin
                    dot_next = prod_reg;
                end
                else if (step_reg <= STEP_DOT2)
                begin
                    dot_next = dot_reg + prod_reg;
                end
                else if (step_reg == STEP_BB0)
                begin
                    bb_next  = pp;
                    neg_next = dot_reg[65];
                    mag_next = dot_reg[65] ? 64'(-dot_reg) : dot_reg[63:0];
                end
                else if (step_reg <= STEP_BB2)
                begin
                    bb_next = bb_reg + pp;
                end
                else if (step_reg == STEP_VV0)
                begin
                    vv_next = pp;
                end
                else if (step_reg < STEP_VV2)
                begin
                    vv_next = vv_sum;
                end
                else if (step_reg == STEP_VV2)
                begin
                    vv_next = vv_sum;
                    if (bb_reg == 64'd0 || vv_sum == 64'd0)
                    begin
                        result_next = '{zero: 1'b1, negative: 1'b0, mag: '0};
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (step_reg == STEP_P0)
                begin
                    p_next = {64'd0, pp};
                end
                else if (step_reg < STEP_P3)
                begin
                    p_next = p_reg + {32'd0, pp, 32'd0};
                end
                else if (step_reg == STEP_P3)
                begin
                    p_next = p_reg + {pp, 64'd0};
                end
                else if (step_reg == STEP_Q0)
                begin
                    q_next = {64'd0, pp};
                end
                else if (step_reg < STEP_Q3)
                begin
                    q_next = q_reg + {32'd0, pp, 32'd0};
                end
                else
                begin
                    r_next     = {4'd0, q_sum, 28'd0};
                    ps_next    = {4'd0, p_reg, 28'd0};
                    xs_next    = '0;
                    c_next     = '0;
                    j_next     = 4'(CW - 1);
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                term_next  = xs_reg + ps_reg;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                if (!sub_w[WW])
                begin
                    r_next  = sub_w[WW-1:0];
                    c_next  = c_reg | bit_w;
                    xs_next = (xs_reg >> 1) + ps_reg;
                end
                else
                begin
                    xs_next = xs_reg >> 1;
                end
                ps_next = ps_reg >> 2;
                if (j_reg == 4'd0)
                begin
                    result_next = '{zero: 1'b0, negative: neg_reg,
                                    mag: (!sub_w[WW]) ? (c_reg | bit_w) : c_reg};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_SUM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        result_reg <= result_next;
        bx_reg <= bx_next; by_reg <= by_next; bz_reg <= bz_next;
        vx_reg <= vx_next; vy_reg <= vy_next; vz_reg <= vz_next;
        prod_reg <= prod_next;
        dot_reg  <= dot_next;
        bb_reg   <= bb_next;
        vv_reg   <= vv_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        xs_reg   <= xs_next;
        ps_reg   <= ps_next;
        term_reg <= term_next;
        c_reg    <= c_next;
        j_reg    <= j_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/pitch_angle_histogram.sv =====
// ----------------------------------------------------------------------------
// Pitch-angle histogram
// Weighted histogram of pitch-angle cosine per probe and per species.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A binned sample passes through 17
// products on the shared multiplier, 15 steps of the cosine search, the
// serial divider and a read-modify-write of the bin store. After reset and
// for each clear transaction the store is swept one entry per cycle over all
// N_PROBES * N_SPECIES * MAX_BINS entries (4096 by default), during which no
// transaction is accepted; configuration writes are taken at any time.
module pitch_angle_histogram #(
    parameter int N_PROBES  = 4,
    parameter int N_SPECIES = 4,
    parameter int MAX_BINS  = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            opcode,
    input  logic [1:0]                            probe,
    input  logic [1:0]                            species,
    input  logic [7:0]                            bin_select,
    input  logic signed [pah_pkg::FIELD_W-1:0]    field_x,
    input  logic signed [pah_pkg::FIELD_W-1:0]    field_y,
    input  logic signed [pah_pkg::FIELD_W-1:0]    field_z,
    input  logic signed [pah_pkg::FIELD_W-1:0]    vel_x,
    input  logic signed [pah_pkg::FIELD_W-1:0]    vel_y,
    input  logic signed [pah_pkg::FIELD_W-1:0]    vel_z,
    input  logic [pah_pkg::WEIGHT_W-1:0]          weight,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pah_pkg::VALUE_W-1:0]           bin_value,
    output logic                                  binned,
    output logic [7:0]                            bin_index,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [pah_pkg::CFG_W-1:0]             cfg_wdata
);

    localparam int DEPTH  = N_PROBES * N_SPECIES * MAX_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int VW     = pah_pkg::VALUE_W;
    localparam int QW     = pah_pkg::QUO_W;
    localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_COS, ST_DIV, ST_READ, ST_DATA, ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic [1:0]           op_reg, op_next;
    logic [1:0]           probe_reg, probe_next;
    logic [1:0]           species_reg, species_next;
    logic [pah_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [7:0]           idx_reg, idx_next;
    logic [VW-1:0]        res_value_reg, res_value_next;
    logic                 res_binned_reg, res_binned_next;
    logic [7:0]           res_index_reg, res_index_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VW-1:0]        bin_value_reg, bin_value_next;
    logic                 binned_reg, binned_next;
    logic [7:0]           bin_index_reg, bin_index_next;
    logic signed [15:0]   cos_min_reg;
    logic [15:0]          bin_width_reg;
    logic [8:0]           bins_in_use_reg;

    logic                 cos_start, cos_done;
    pah_pkg::cos_result_t cos_res;
    logic                 div_start, div_done;
    logic [QW-1:0]        quotient;
    logic signed [16:0]   cos_signed, diff;
    logic [QW-1:0]        lim;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [VW-1:0]        ram_wdata, ram_rdata;
    logic [VW:0]          sum_w;
    logic [VW-1:0]        sat_w;
    logic                 sel_ok;

    function automatic logic [ADDR_W-1:0] bin_addr(input logic [1:0] p,
                                                   input logic [1:0] s,
                                                   input logic [QW-1:0] b);
        bin_addr = ADDR_W'((32'(p) * N_SPECIES + 32'(s)) * MAX_BINS + 32'(b));
    endfunction

    assign cos_signed = cos_res.negative ? -17'(cos_res.mag) : 17'(cos_res.mag);
    assign diff       = cos_signed - 17'(cos_min_reg);
    assign lim        = (32'(bins_in_use_reg) < MAX_BINS) ? QW'(bins_in_use_reg)
                                                          : QW'(MAX_BINS);
    assign sum_w      = {1'b0, ram_rdata} + (VW + 1)'(weight_reg);
    assign sat_w      = sum_w[VW] ? VALUE_MAX : sum_w[VW-1:0];
    assign sel_ok     = (32'(probe) < N_PROBES) && (32'(species) < N_SPECIES);
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_reply_next  = clr_reply_reg;
        op_next         = op_reg;
        probe_next      = probe_reg;
        species_next    = species_reg;
        weight_next     = weight_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_binned_next = res_binned_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        bin_value_next  = bin_value_reg;
        binned_next     = binned_reg;
        bin_index_next  = bin_index_reg;
        cos_start       = 1'b0;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = sat_w;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = clr_reply_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    probe_next      = probe;
                    species_next    = species;
                    weight_next     = weight;
                    res_value_next  = '0;
                    res_binned_next = 1'b0;
                    res_index_next  = '0;
                    state_next      = ST_FINISH;
                    case (opcode)
                        pah_pkg::OP_SAMPLE:
                        begin
                            if (sel_ok)
                            begin
                                cos_start  = 1'b1;
                                state_next = ST_COS;
                            end
                        end
                        pah_pkg::OP_READ:
                        begin
                            res_index_next = bin_select;
                            if (sel_ok && 32'(bin_select) < MAX_BINS)
                            begin
                                addr_next  = bin_addr(probe, species, QW'(bin_select));
                                state_next = ST_READ;
                            end
                        end
                        pah_pkg::OP_CLEAR:
                        begin
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_COS:
            begin
                if (cos_done)
                begin
                    if (cos_res.zero || bin_width_reg == 16'd0 || diff < 0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (quotient >= lim)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        addr_next  = bin_addr(probe_reg, species_reg, quotient);
                        idx_next   = quotient[7:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (op_reg == pah_pkg::OP_SAMPLE)
                begin
                    ram_we          = 1'b1;
                    res_value_next  = sat_w;
                    res_binned_next = 1'b1;
                    res_index_next  = idx_reg;
                end
                else
                begin
                    res_value_next = ram_rdata;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    bin_value_next = res_value_reg;
                    binned_next    = res_binned_reg;
                    bin_index_next = res_index_reg;
                    clr_reply_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            clr_reply_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            cos_min_reg     <= pah_pkg::COS_MIN_RESET;
            bin_width_reg   <= pah_pkg::BIN_WIDTH_RESET;
            bins_in_use_reg <= pah_pkg::BINS_IN_USE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pah_pkg::REG_COS_MIN:     cos_min_reg     <= cfg_wdata;
                    pah_pkg::REG_BIN_WIDTH:   bin_width_reg   <= cfg_wdata;
                    pah_pkg::REG_BINS_IN_USE: bins_in_use_reg <= cfg_wdata[8:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        probe_reg      <= probe_next;
        species_reg    <= species_next;
        weight_reg     <= weight_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_binned_reg <= res_binned_next;
        res_index_reg  <= res_index_next;
        bin_value_reg  <= bin_value_next;
        binned_reg     <= binned_next;
        bin_index_reg  <= bin_index_next;
    end

    pah_cos u_cos (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cos_start),
        .field_x (field_x),
        .field_y (field_y),
        .field_z (field_z),
        .vel_x   (vel_x),
        .vel_y   (vel_y),
        .vel_z   (vel_z),
        .done    (cos_done),
        .result  (cos_res)
    );

    pah_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff[QW-1:0]),
        .divisor  (bin_width_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    pah_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign bin_value = bin_value_reg;
    assign binned    = binned_reg;
    assign bin_index = bin_index_reg;

endmodule

// ===== tb/pitch_angle_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// Pitch-angle histogram testbench
// Drives sample, read and clear transactions with bursty input and a stalling
// output, predicts every result from a local model of the cosine search, the
// binning and the bin store, and compares each result field by field.
// ----------------------------------------------------------------------------
module pitch_angle_histogram_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NP = 4;
    localparam int NS = 4;
    localparam int NB = 256;
    localparam int DEPTH = NP * NS * NB;
    localparam logic [47:0] VMAX = 48'hFFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  prb;
        logic [1:0]  spc;
        logic [7:0]  sel;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] wt;
    } txn_t;

    typedef struct packed {
        logic [47:0] value;
        logic        hit;
        logic [7:0]  index;
    } bin_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] opcode;
    logic [1:0] probe;
    logic [1:0] species;
    logic [7:0] bin_select;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0] weight;
    logic out_valid;
    logic out_ready;
    logic [47:0] bin_value;
    logic binned;
    logic [7:0] bin_index;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_wdata;

    pitch_angle_histogram u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .probe(probe), .species(species), .bin_select(bin_select),
        .field_x(field_x), .field_y(field_y), .field_z(field_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .weight(weight),
        .out_valid(out_valid), .out_ready(out_ready), .bin_value(bin_value),
        .binned(binned), .bin_index(bin_index),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    logic [47:0] hist_model [DEPTH];
    logic signed [15:0] model_cos_min;
    logic [15:0] model_bin_width;
    logic [8:0] model_bins;

    txn_t pending_txns[$];
    bin_result_t expected_bins[$];
    int mismatches;
    longint cycles = 0;
    bit hold_input;
    bit stall_req;
    int long_stall;
    int gap_left;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Largest c in [0, 16384] with c^2 |B|^2 |v|^2 <= (B.v)^2 * 2^28.
    function automatic bit pitch_cosine(input txn_t t, output logic signed [15:0] cosv);
        logic signed [63:0] b [3];
        logic signed [63:0] v [3];
        logic signed [66:0] dot;
        logic [65:0] bb;
        logic [65:0] vv;
        logic [65:0] mag;
        logic [131:0] prod;
        logic [163:0] lhs;
        logic [163:0] rhs;
        int c;
        int tr;
        b[0] = signed'(t.bx); b[1] = signed'(t.by); b[2] = signed'(t.bz);
        v[0] = signed'(t.vx); v[1] = signed'(t.vy); v[2] = signed'(t.vz);
        dot = 0; bb = 0; vv = 0;
        for (int k = 0; k < 3; k++)
        begin
            dot += b[k] * v[k];
            bb += 66'(b[k] * b[k]);
            vv += 66'(v[k] * v[k]);
        end
        if (bb == 0 || vv == 0)
            return 1'b0;
        mag = (dot < 0) ? 66'(-dot) : 66'(dot);
        prod = 132'(bb) * 132'(vv);
        rhs = (164'(mag) * 164'(mag)) << 28;
        c = 0;
        for (int bitv = 1 << 14; bitv > 0; bitv >>= 1)
        begin
            tr = c | bitv;
            if (tr <= 16384)
            begin
                lhs = 164'(tr * tr) * 164'(prod);
                if (lhs <= rhs)
                    c = tr;
            end
        end
        cosv = (dot < 0) ? 16'(-c) : 16'(c);
        return 1'b1;
    endfunction

    function automatic bin_result_t histogram_update(input txn_t t);
        bin_result_t r;
        logic signed [15:0] cosv;
        int diff;
        int idx;
        int lim;
        int base;
        logic [48:0] sum;
        r = '0;
        base = (int'(t.prb) * NS + int'(t.spc)) * NB;
        if (t.op == pah_pkg::OP_SAMPLE)
        begin
            if (!pitch_cosine(t, cosv))
                return r;
            diff = int'(cosv) - int'(model_cos_min);
            if (model_bin_width == 0 || diff < 0)
                return r;
            idx = diff / int'(model_bin_width);
            lim = (model_bins < NB) ? int'(model_bins) : NB;
            if (idx >= lim)
                return r;
            sum = 49'(hist_model[base + idx]) + 49'(t.wt);
            if (sum > 49'(VMAX))
                sum = 49'(VMAX);
            hist_model[base + idx] = sum[47:0];
            r.value = sum[47:0];
            r.hit = 1'b1;
            r.index = idx[7:0];
        end
        else if (t.op == pah_pkg::OP_READ)
        begin
            r.index = t.sel;
            r.value = hist_model[base + int'(t.sel)];
        end
        else if (t.op == pah_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++)
                hist_model[i] = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0; probe <= '0; species <= '0; bin_select <= '0;
            field_x <= '0; field_y <= '0; field_z <= '0;
            vel_x <= '0; vel_y <= '0; vel_z <= '0; weight <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_bins.push_back(histogram_update(pending_txns.pop_front()));
            end
            if ((!in_valid || in_ready) )
            begin
                if (pending_txns.size() > (in_valid && in_ready ? 0 : 0) && !hold_input
                    && gap_left == 0 && !(in_valid && in_ready && pending_txns.size() == 0))
                begin
                    opcode <= pending_txns[0].op;
                    probe <= pending_txns[0].prb;
                    species <= pending_txns[0].spc;
                    bin_select <= pending_txns[0].sel;
                    field_x <= pending_txns[0].bx;
                    field_y <= pending_txns[0].by;
                    field_z <= pending_txns[0].bz;
                    vel_x <= pending_txns[0].vx;
                    vel_y <= pending_txns[0].vy;
                    vel_z <= pending_txns[0].vz;
                    weight <= pending_txns[0].wt;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_stall <= 0;
        else if (stall_req && long_stall == 0)
            long_stall <= 1500;
        else if (long_stall > 0)
            long_stall <= long_stall - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bins.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected result transaction: value %h binned %b index %0d",
                                 bin_value, binned, bin_index);
                    mismatches <= mismatches + 1;
                end
                else if (expected_bins[0] != {bin_value, binned, bin_index})
                begin
                    if (mismatches < 10)
                        $display("Mismatch: expected value %h binned %b index %0d, got %h %b %0d",
                                 expected_bins[0].value, expected_bins[0].hit,
                                 expected_bins[0].index, bin_value, binned, bin_index);
                    mismatches <= mismatches + 1;
                    void'(expected_bins.pop_front());
                end
                else
                    void'(expected_bins.pop_front());
            end
            if (long_stall > 0)
                out_ready <= 1'b0;
            else if ((cycles % 200) < 60)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pah_pkg::REG_COS_MIN)
            model_cos_min = signed'(val);
        else if (idx == pah_pkg::REG_BIN_WIDTH)
            model_bin_width = val;
        else
            model_bins = val[8:0];
    endtask

    task automatic drain();
        while (pending_txns.size() != 0 || in_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic txn_t rand_txn();
        txn_t t;
        int k;
        int s;
        t.op = ($urandom_range(0, 9) < 7) ? pah_pkg::OP_SAMPLE : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 40) != 0 && t.op == pah_pkg::OP_CLEAR)
            t.op = pah_pkg::OP_READ;
        t.prb = 2'($urandom);
        t.spc = 2'($urandom);
        t.sel = 8'($urandom);
        s = $urandom_range(0, 3);
        t.bx = (s == 0) ? $urandom : 32'(signed'($urandom_range(0, 4000)) - 2000);
        t.by = (s == 0) ? $urandom : 32'(signed'($urandom_range(0, 4000)) - 2000);
        t.bz = (s == 0) ? $urandom : 32'(signed'($urandom_range(0, 4000)) - 2000);
        t.vx = (s <= 1) ? $urandom : 32'(signed'($urandom_range(0, 60000)) - 30000);
        t.vy = (s <= 1) ? $urandom : 32'(signed'($urandom_range(0, 60000)) - 30000);
        t.vz = (s <= 1) ? $urandom : 32'(signed'($urandom_range(0, 60000)) - 30000);
        if ($urandom_range(0, 30) == 0)
            {t.bx, t.by, t.bz} = '0;
        if ($urandom_range(0, 30) == 0)
            {t.vx, t.vy, t.vz} = '0;
        k = $urandom_range(0, 9);
        t.wt = (k == 0) ? 32'hFFFF_FFFF : $urandom;
        return t;
    endfunction

    function automatic txn_t mk(input logic [1:0] op, input logic [31:0] bx, by, bz,
                                input logic [31:0] vx, vy, vz, input logic [31:0] wt);
        txn_t t;
        t = '{op: op, prb: 2'($urandom), spc: 2'($urandom), sel: 8'($urandom),
              bx: bx, by: by, bz: bz, vx: vx, vy: vy, vz: vz, wt: wt};
        return t;
    endfunction

    initial
    begin
        txn_t t;
        hold_input = 1'b0;
        stall_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        model_cos_min = signed'(pah_pkg::COS_MIN_RESET);
        model_bin_width = pah_pkg::BIN_WIDTH_RESET;
        model_bins = pah_pkg::BINS_IN_USE_RESET;
        for (int i = 0; i < DEPTH; i++)
            hist_model[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 1, 0, 0, 5, 0, 0, 32'hFFFF_FFFF));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 1, 0, 0, -5, 0, 0, 7));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 1));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 3));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 0, 0, 0, 4, 5, 6, 9));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 4, 5, 6, 0, 0, 0, 9));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 1, 0, 0, 0, 1, 0, 11));
        pending_txns.push_back(mk(pah_pkg::OP_SAMPLE, 3, 4, 0, 4, 3, 0, 12));
        for (int i = 0; i < 4; i++)
        begin
            t = mk(pah_pkg::OP_SAMPLE, 1, 0, 0, 1, 0, 0, 32'hFFFF_FFFF);
            t.prb = 2'd3; t.spc = 2'd3;
            pending_txns.push_back(t);
        end
        t = mk(pah_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0); t.prb = 3; t.spc = 3; t.sel = 199;
        pending_txns.push_back(t);
        t = mk(pah_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0); t.sel = 255;
        pending_txns.push_back(t);
        t = mk(pah_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0); t.sel = 0;
        pending_txns.push_back(t);
        pending_txns.push_back(mk(OP_NONE, 1, 1, 1, 1, 1, 1, 1));
        pending_txns.push_back(mk(pah_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        t = mk(pah_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0); t.prb = 3; t.spc = 3; t.sel = 199;
        pending_txns.push_back(t);
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: begin write_reg(pah_pkg::REG_COS_MIN, 16'hC000);
                         write_reg(pah_pkg::REG_BIN_WIDTH, 16'd1);
                         write_reg(pah_pkg::REG_BINS_IN_USE, 9'd256); end
                1: begin write_reg(pah_pkg::REG_COS_MIN, 16'h4000);
                         write_reg(pah_pkg::REG_BIN_WIDTH, 16'd32768);
                         write_reg(pah_pkg::REG_BINS_IN_USE, 9'd1); end
                2: begin write_reg(pah_pkg::REG_COS_MIN, 16'hC000);
                         write_reg(pah_pkg::REG_BIN_WIDTH, 16'd0); end
                3: begin write_reg(pah_pkg::REG_BIN_WIDTH, 16'd8);
                         write_reg(pah_pkg::REG_BINS_IN_USE, 9'd511);
                         write_reg(pah_pkg::REG_COS_MIN,
                                   16'($urandom_range(0, 32768) - 16384)); end
                4: begin write_reg(pah_pkg::REG_COS_MIN, 16'hFFFF);
                         write_reg(pah_pkg::REG_BIN_WIDTH, 16'hFFFF);
                         write_reg(pah_pkg::REG_BINS_IN_USE, 9'h1FF); end
                5: begin write_reg(pah_pkg::REG_COS_MIN, 16'h8000);
                         write_reg(pah_pkg::REG_BIN_WIDTH, 16'd300);
                         write_reg(pah_pkg::REG_BINS_IN_USE, 9'd0); end
                default: begin write_reg(pah_pkg::REG_COS_MIN, pah_pkg::COS_MIN_RESET);
                               write_reg(pah_pkg::REG_BIN_WIDTH, pah_pkg::BIN_WIDTH_RESET);
                               write_reg(pah_pkg::REG_BINS_IN_USE,
                                         16'(pah_pkg::BINS_IN_USE_RESET)); end
            endcase
            for (int i = 0; i < 150; i++)
                pending_txns.push_back(rand_txn());
            if (phase == 3)
            begin
                stall_req = 1'b1;
                while (long_stall == 0)
                    @(posedge clk);
                stall_req = 1'b0;
                while (long_stall > 0)
                    @(posedge clk);
            end
            if (phase == 5)
            begin
                while (pending_txns.size() >= 75)
                    @(posedge clk);
                hold_input = 1'b1;
                while (expected_bins.size() != 0 || in_valid)
                    @(posedge clk);
                hold_input = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
